### hdl/iat_pkg.sv
// shared types, token codes and lookup functions of the indentation-aware tokenizer
`timescale 1ns / 1ps
package iat_pkg;

    localparam int INDENT_DEPTH = 16;
    localparam int IND_W        = 8;
    localparam int POS_W        = 16;
    localparam int LVL_W        = $clog2(INDENT_DEPTH + 1);
    localparam int LVL_IDX_W    = $clog2(INDENT_DEPTH);
    localparam int WORD_LEN     = 7;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);

    localparam logic [5:0] K_NEWLINE = 6'd0;
    localparam logic [5:0] K_INDENT  = 6'd1;
    localparam logic [5:0] K_DEDENT  = 6'd2;
    localparam logic [5:0] K_EOF     = 6'd3;
    localparam logic [5:0] K_ERROR   = 6'd4;
    localparam logic [5:0] K_NUMBER  = 6'd5;
    localparam logic [5:0] K_STRING  = 6'd6;
    localparam logic [5:0] K_IDENT   = 6'd7;
    localparam logic [5:0] K_DOT     = 6'd52;
    localparam logic [5:0] K_NONE    = 6'd0;

    localparam logic [2:0] E_NONE     = 3'd0;
    localparam logic [2:0] E_MISMATCH = 3'd1;
    localparam logic [2:0] E_BINARY   = 3'd2;
    localparam logic [2:0] E_HEX      = 3'd3;
    localparam logic [2:0] E_EXPONENT = 3'd4;
    localparam logic [2:0] E_STRING   = 3'd5;
    localparam logic [2:0] E_BADCHAR  = 3'd6;
    localparam logic [2:0] E_FULL     = 3'd7;

    localparam logic FUNC_CHAR = 1'b0;
    localparam logic FUNC_END  = 1'b1;

    typedef enum logic [4:0] {
        M_LINE, M_BLANK_CR, M_BLANK_COMMENT, M_TOP, M_COMMENT, M_CR, M_DOT,
        M_ZERO, M_INT, M_INTDOT, M_FRAC, M_EXP0, M_EXP1, M_EXPD, M_BINP,
        M_BIND, M_HEXP, M_HEXD, M_STR, M_ESC, M_IDENT, M_OP,
        M_IND, M_DED, M_LATEDOT
    } t_mode;

    typedef enum logic [2:0] {
        PH_FETCH, PH_FEED, PH_FLUSH, PH_NL, PH_DED, PH_EOF, PH_END
    } t_phase;

    typedef struct packed {
        logic       is_digit;
        logic       is_alpha;
        logic       is_space;
        logic       is_break;
        logic       hex_ok;
        logic [3:0] hex_val;
        logic       needs_pair;
    } t_char_info;

    typedef struct packed {
        logic [5:0]       kind;
        logic [2:0]       err;
        logic [POS_W-1:0] line;
        logic [POS_W-1:0] col;
        logic [POS_W-1:0] len;
        logic [63:0]      val;
        logic             last;
    } t_token;

    function automatic logic [5:0] single_kind(input logic [7:0] c);
        logic [5:0] k;
        k = K_NONE;
        case (c)
            "+": k = 6'd25;  "-": k = 6'd26;  "*": k = 6'd27;  "/": k = 6'd28;
            "^": k = 6'd30;  "&": k = 6'd32;  "|": k = 6'd33;  "~": k = 6'd34;
            "=": k = 6'd37;  "<": k = 6'd41;  ">": k = 6'd43;  "(": k = 6'd45;
            ")": k = 6'd46;  "[": k = 6'd47;  "]": k = 6'd48;  "{": k = 6'd49;
            "}": k = 6'd50;  ",": k = 6'd51;  ".": k = K_DOT;  ":": k = 6'd53;
            ";": k = 6'd54;  "@": k = 6'd55;
            default: k = K_NONE;
        endcase
        return k;
    endfunction

    function automatic logic [5:0] pair_kind(input logic [7:0] h, input logic [7:0] c);
        logic [5:0] k;
        k = K_NONE;
        case ({h, c})
            "**": k = 6'd29;  "->": k = 6'd56;  "^^": k = 6'd31;  "==": k = 6'd39;
            "!=": k = 6'd40;  "<=": k = 6'd42;  "<<": k = 6'd35;  ">=": k = 6'd44;
            ">>": k = 6'd36;  ":=": k = 6'd38;
            default: k = K_NONE;
        endcase
        return k;
    endfunction

    // exact keyword match on the stored word start
    function automatic logic [5:0] word_kind(input logic [WORD_LEN-1:0][7:0] w,
                                             input logic [POS_W-1:0] len);
        logic [5:0] k;
        k = K_IDENT;
        case (len)
            POS_W'(2): begin
                case ({w[0], w[1]})
                    "if": k = 6'd9;  "in": k = 6'd14;  "or": k = 6'd17;  "as": k = 6'd24;
                    default: k = K_IDENT;
                endcase
            end
            POS_W'(3): begin
                case ({w[0], w[1], w[2]})
                    "def": k = 6'd8;   "for": k = 6'd13;  "and": k = 6'd16;
                    "not": k = 6'd18;  "try": k = 6'd22;
                    default: k = K_IDENT;
                endcase
            end
            POS_W'(4): begin
                case ({w[0], w[1], w[2], w[3]})
                    "else": k = 6'd10;  "elif": k = 6'd11;
                    "True", "true": k = 6'd19;
                    "None", "none": k = 6'd21;
                    default: k = K_IDENT;
                endcase
            end
            POS_W'(5): begin
                case ({w[0], w[1], w[2], w[3], w[4]})
                    "while": k = 6'd12;
                    "False", "false": k = 6'd20;
                    default: k = K_IDENT;
                endcase
            end
            POS_W'(6): begin
                case ({w[0], w[1], w[2], w[3], w[4], w[5]})
                    "return": k = 6'd15;  "except": k = 6'd23;
                    default: k = K_IDENT;
                endcase
            end
            default: k = K_IDENT;
        endcase
        return k;
    endfunction

    function automatic logic [POS_W-1:0] sat_pos(input logic [POS_W-1:0] v);
        return (v == {POS_W{1'b1}}) ? v : v + POS_W'(1);
    endfunction

    function automatic t_token mk_tok(input logic [5:0] kind, input logic [2:0] err,
                                      input logic [POS_W-1:0] line,
                                      input logic [POS_W-1:0] col,
                                      input logic [POS_W-1:0] len,
                                      input logic [63:0] val);
        t_token t;
        t.kind = kind;
        t.err  = err;
        t.line = line;
        t.col  = col;
        t.len  = len;
        t.val  = val;
        t.last = 1'b0;
        return t;
    endfunction

endpackage

### hdl/iat_front.sv
// input queue and character classifier
`timescale 1ns / 1ps
module iat_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  logic                i_func,
    input  logic [7:0]          i_char_byte,
    output logic                o_valid,
    output logic                o_func,
    output logic [7:0]          o_byte,
    output iat_pkg::t_char_info o_info,
    input  logic                i_pop
);

    logic [8:0]                   r_mem [iat_pkg::QUEUE_DEPTH];
    logic [iat_pkg::QPTR_W-1:0]   r_wp, r_rp;
    logic [iat_pkg::QPTR_W:0]     r_cnt;
    logic                         w_wr, w_rd;
    logic [7:0]                   w_c;

    assign full    = (r_cnt == (iat_pkg::QPTR_W + 1)'(iat_pkg::QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign w_wr    = push && !full;
    assign w_rd    = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) r_wp <= r_wp + 1'b1;
            if (w_rd) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (iat_pkg::QPTR_W + 1)'(w_wr) - (iat_pkg::QPTR_W + 1)'(w_rd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) r_mem[r_wp] <= {i_func, i_char_byte};
    end

    assign o_func = r_mem[r_rp][8];
    assign o_byte = r_mem[r_rp][7:0];
    assign w_c    = o_byte;

    always_comb begin
        o_info.is_digit   = (w_c >= "0") && (w_c <= "9");
        o_info.is_alpha   = ((w_c >= "a") && (w_c <= "z")) || ((w_c >= "A") && (w_c <= "Z"))
                            || (w_c == "_");
        o_info.is_space   = (w_c == " ") || (w_c == 8'h09);
        o_info.is_break   = (w_c == 8'h0A) || (w_c == 8'h0D);
        o_info.needs_pair = (w_c inside {"*", "-", "^", "=", "!", "<", ">", ":"});
        o_info.hex_ok     = 1'b1;
        o_info.hex_val    = 4'd0;
        if (o_info.is_digit) begin
            o_info.hex_val = 4'(w_c - "0");
        end else if ((w_c >= "a") && (w_c <= "f")) begin
            o_info.hex_val = 4'(w_c - "a" + 8'd10);
        end else if ((w_c >= "A") && (w_c <= "F")) begin
            o_info.hex_val = 4'(w_c - "A" + 8'd10);
        end else begin
            o_info.hex_ok = 1'b0;
        end
    end

endmodule

### hdl/iat_out_queue.sv
// result queue between the lexer engine and the consumer
`timescale 1ns / 1ps
module iat_out_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  iat_pkg::t_token i_tok,
    output logic            o_full,
    output logic            empty,
    input  logic            pop,
    output iat_pkg::t_token o_tok
);

    iat_pkg::t_token              r_mem [iat_pkg::QUEUE_DEPTH];
    logic [iat_pkg::QPTR_W-1:0]   r_wp, r_rp;
    logic [iat_pkg::QPTR_W:0]     r_cnt;
    logic                         w_wr, w_rd;

    assign o_full = (r_cnt == (iat_pkg::QPTR_W + 1)'(iat_pkg::QUEUE_DEPTH));
    assign empty  = (r_cnt == '0);
    assign w_wr   = i_push && !o_full;
    assign w_rd   = pop && !empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) r_wp <= r_wp + 1'b1;
            if (w_rd) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (iat_pkg::QPTR_W + 1)'(w_wr) - (iat_pkg::QPTR_W + 1)'(w_rd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) r_mem[r_wp] <= i_tok;
    end

    assign o_tok = r_mem[r_rp];

endmodule

### hdl/iat_engine.sv
// lexer engine: one lexer step per cycle unless stalled, indent stack, one pending token
`timescale 1ns / 1ps
module iat_engine (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_func,
    input  logic [7:0]          i_in_byte,
    input  iat_pkg::t_char_info i_in_info,
    output logic                o_in_pop,
    input  logic                i_out_full,
    output logic                o_out_push,
    output iat_pkg::t_token     o_out_tok
);

    localparam int PW = iat_pkg::POS_W;
    localparam int IW = iat_pkg::IND_W;
    localparam int LW = iat_pkg::LVL_W;

    iat_pkg::t_phase     r_phase, n_phase;
    iat_pkg::t_mode      r_mode, n_mode;
    logic [IW-1:0]       r_levels [iat_pkg::INDENT_DEPTH];
    logic [LW-1:0]       r_lvl_cnt, n_lvl_cnt;
    logic [PW-1:0]       r_line, n_line, r_col, n_col;
    logic [PW-1:0]       r_tline, n_tline, r_tcol, n_tcol, r_len, n_len;
    logic [IW-1:0]       r_lead, n_lead;
    logic [63:0]         r_acc, n_acc;
    logic [7:0]          r_held, n_held, r_quote, n_quote;
    logic                r_held_v, n_held_v, r_emitted, n_emitted, r_lastnl, n_lastnl;
    logic [iat_pkg::WORD_LEN-1:0][7:0] r_word;
    logic [7:0]          r_c;
    iat_pkg::t_char_info r_ci;
    iat_pkg::t_token     r_pend;
    logic                r_pend_v;

    logic                w_act, w_adv, w_end_push;
    logic                e_v;
    iat_pkg::t_token     e_tok;
    logic                lv_we;
    logic [IW-1:0]       lv_data;
    logic                wd_we;
    logic [2:0]          wd_idx;
    logic [IW-1:0]       w_top;
    logic [5:0]          w_sk, w_pk;

    assign w_top = (r_lvl_cnt == LW'(1)) ? '0
                 : r_levels[iat_pkg::LVL_IDX_W'(r_lvl_cnt - LW'(1))];
    assign w_sk  = iat_pkg::single_kind(r_c);
    assign w_pk  = iat_pkg::pair_kind(r_held, r_c);

    // work only when a new token would not overwrite a pending one stuck on a full queue
    assign w_act = (r_phase != iat_pkg::PH_FETCH) && (r_phase != iat_pkg::PH_END)
                   && !(r_pend_v && i_out_full);
    assign w_end_push = (r_phase == iat_pkg::PH_END) && r_pend_v && !i_out_full;

    // datapath of one lexer step
    always_comb begin
        n_mode    = r_mode;
        n_lvl_cnt = r_lvl_cnt;
        n_line    = r_line;
        n_col     = r_col;
        n_tline   = r_tline;
        n_tcol    = r_tcol;
        n_len     = r_len;
        n_lead    = r_lead;
        n_acc     = r_acc;
        n_held    = r_held;
        n_held_v  = r_held_v;
        n_quote   = r_quote;
        n_emitted = r_emitted;
        n_lastnl  = r_lastnl;
        e_v       = 1'b0;
        e_tok     = iat_pkg::mk_tok(iat_pkg::K_NONE, iat_pkg::E_NONE, '0, '0, '0, '0);
        w_adv     = 1'b0;
        lv_we     = 1'b0;
        lv_data   = r_lead;
        wd_we     = 1'b0;
        wd_idx    = r_len[2:0];

        if (w_act) begin
            case (r_phase)
                iat_pkg::PH_FEED: begin
                    case (r_mode)
                        iat_pkg::M_LINE: begin
                            if (r_ci.is_space) begin
                                if (r_lead != {IW{1'b1}}) n_lead = r_lead + IW'(1);
                                n_col = iat_pkg::sat_pos(r_col);
                                w_adv = 1'b1;
                            end else if (r_c == 8'h0A || r_c == 8'h0D) begin
                                n_line = iat_pkg::sat_pos(r_line);
                                n_col  = PW'(1);
                                n_lead = '0;
                                if (r_c == 8'h0D) n_mode = iat_pkg::M_BLANK_CR;
                                w_adv = 1'b1;
                            end else if (r_c == "#") begin
                                n_col  = iat_pkg::sat_pos(r_col);
                                n_mode = iat_pkg::M_BLANK_COMMENT;
                                w_adv  = 1'b1;
                            end else begin
                                n_mode = iat_pkg::M_IND;
                            end
                        end
                        iat_pkg::M_IND: begin
                            n_mode = iat_pkg::M_TOP;
                            if (r_lead > w_top) begin
                                e_v = 1'b1;
                                if (r_lvl_cnt < LW'(iat_pkg::INDENT_DEPTH)) begin
                                    lv_we     = 1'b1;
                                    n_lvl_cnt = r_lvl_cnt + LW'(1);
                                    e_tok = iat_pkg::mk_tok(iat_pkg::K_INDENT, iat_pkg::E_NONE,
                                                            r_line, PW'(1), '0, '0);
                                end else begin
                                    e_tok = iat_pkg::mk_tok(iat_pkg::K_ERROR, iat_pkg::E_FULL,
                                                            r_line, PW'(1), '0, '0);
                                end
                            end else if (r_lead < w_top) begin
                                n_mode = iat_pkg::M_DED;
                            end
                        end
                        iat_pkg::M_DED: begin
                            if (r_lvl_cnt > LW'(1) && w_top > r_lead) begin
                                n_lvl_cnt = r_lvl_cnt - LW'(1);
                                e_v   = 1'b1;
                                e_tok = iat_pkg::mk_tok(iat_pkg::K_DEDENT, iat_pkg::E_NONE,
                                                        r_line, PW'(1), '0, '0);
                            end else begin
                                n_mode = iat_pkg::M_TOP;
                                if (w_top != r_lead) begin
                                    e_v   = 1'b1;
                                    e_tok = iat_pkg::mk_tok(iat_pkg::K_ERROR,
                                                            iat_pkg::E_MISMATCH,
                                                            r_line, PW'(1), '0, '0);
                                end
                            end
                        end
                        iat_pkg::M_BLANK_CR: begin
                            n_mode = iat_pkg::M_LINE;
                            w_adv  = (r_c == 8'h0A);
                        end
                        iat_pkg::M_BLANK_COMMENT, iat_pkg::M_COMMENT: begin
                            if (r_ci.is_break) begin
                                n_mode = (r_mode == iat_pkg::M_COMMENT) ? iat_pkg::M_TOP
                                                                       : iat_pkg::M_LINE;
                            end else begin
                                n_col = iat_pkg::sat_pos(r_col);
                                w_adv = 1'b1;
                            end
                        end
                        iat_pkg::M_CR: begin
                            e_v    = 1'b1;
                            e_tok  = iat_pkg::mk_tok(iat_pkg::K_NEWLINE, iat_pkg::E_NONE,
                                                     r_tline, r_tcol,
                                                     (r_c == 8'h0A) ? PW'(2) : PW'(1), '0);
                            n_mode = iat_pkg::M_LINE;
                            w_adv  = (r_c == 8'h0A);
                        end
                        iat_pkg::M_TOP: begin
                            w_adv = 1'b1;
                            if (r_ci.is_space) begin
                                n_col = iat_pkg::sat_pos(r_col);
                            end else if (r_c == "#") begin
                                n_col  = iat_pkg::sat_pos(r_col);
                                n_mode = iat_pkg::M_COMMENT;
                            end else if (r_c == 8'h0A) begin
                                e_v    = 1'b1;
                                e_tok  = iat_pkg::mk_tok(iat_pkg::K_NEWLINE, iat_pkg::E_NONE,
                                                         r_line, r_col, PW'(1), '0);
                                n_line = iat_pkg::sat_pos(r_line);
                                n_col  = PW'(1);
                                n_lead = '0;
                                n_mode = iat_pkg::M_LINE;
                            end else begin
                                n_tline = r_line;
                                n_tcol  = r_col;
                                n_len   = '0;
                                n_acc   = '0;
                                if (r_c == 8'h0D) begin
                                    n_line = iat_pkg::sat_pos(r_line);
                                    n_col  = PW'(1);
                                    n_lead = '0;
                                    n_mode = iat_pkg::M_CR;
                                end else begin
                                    n_len = PW'(1);
                                    n_col = iat_pkg::sat_pos(r_col);
                                    if (r_ci.is_digit) begin
                                        n_mode = (r_c == "0") ? iat_pkg::M_ZERO : iat_pkg::M_INT;
                                    end else if (r_c == ".") begin
                                        n_held   = r_c;
                                        n_held_v = 1'b1;
                                        n_mode   = iat_pkg::M_DOT;
                                    end else if (r_c == 8'h22 || r_c == 8'h27) begin
                                        n_quote = r_c;
                                        n_mode  = iat_pkg::M_STR;
                                    end else if (r_ci.is_alpha) begin
                                        wd_we  = 1'b1;
                                        wd_idx = 3'd0;
                                        n_mode = iat_pkg::M_IDENT;
                                    end else if (r_ci.needs_pair) begin
                                        n_held   = r_c;
                                        n_held_v = 1'b1;
                                        n_mode   = iat_pkg::M_OP;
                                    end else begin
                                        e_v = 1'b1;
                                        if (w_sk != iat_pkg::K_NONE)
                                            e_tok = iat_pkg::mk_tok(w_sk, iat_pkg::E_NONE,
                                                                    n_tline, n_tcol, n_len, '0);
                                        else
                                            e_tok = iat_pkg::mk_tok(iat_pkg::K_ERROR,
                                                                    iat_pkg::E_BADCHAR,
                                                                    n_tline, n_tcol, n_len, '0);
                                    end
                                end
                            end
                        end
                        iat_pkg::M_DOT: begin
                            n_held   = '0;
                            n_held_v = 1'b0;
                            if (r_ci.is_digit) begin
                                n_len  = iat_pkg::sat_pos(r_len);
                                n_col  = iat_pkg::sat_pos(r_col);
                                n_mode = iat_pkg::M_FRAC;
                                w_adv  = 1'b1;
                            end else begin
                                e_v    = 1'b1;
                                e_tok  = iat_pkg::mk_tok(iat_pkg::K_DOT, iat_pkg::E_NONE,
                                                         r_tline, r_tcol, r_len, '0);
                                n_mode = iat_pkg::M_TOP;
                            end
                        end
                        iat_pkg::M_ZERO: begin
                            if (r_c == "b" || r_c == "B" || r_c == "x" || r_c == "X") begin
                                n_len  = iat_pkg::sat_pos(r_len);
                                n_col  = iat_pkg::sat_pos(r_col);
                                n_mode = (r_c == "b" || r_c == "B") ? iat_pkg::M_BINP
                                                                     : iat_pkg::M_HEXP;
                                w_adv  = 1'b1;
                            end else begin
                                n_mode = iat_pkg::M_INT;
                            end
                        end
                        iat_pkg::M_INT, iat_pkg::M_FRAC, iat_pkg::M_EXPD: begin
                            if (r_ci.is_digit) begin
                                n_len = iat_pkg::sat_pos(r_len);
                                n_col = iat_pkg::sat_pos(r_col);
                                w_adv = 1'b1;
                            end else if (r_c == "." && r_mode == iat_pkg::M_INT) begin
                                n_held   = r_c;
                                n_held_v = 1'b1;
                                n_col    = iat_pkg::sat_pos(r_col);
                                n_mode   = iat_pkg::M_INTDOT;
                                w_adv    = 1'b1;
                            end else if ((r_c == "e" || r_c == "E")
                                         && r_mode != iat_pkg::M_EXPD) begin
                                n_len  = iat_pkg::sat_pos(r_len);
                                n_col  = iat_pkg::sat_pos(r_col);
                                n_mode = iat_pkg::M_EXP0;
                                w_adv  = 1'b1;
                            end else begin
                                e_v    = 1'b1;
                                e_tok  = iat_pkg::mk_tok(iat_pkg::K_NUMBER, iat_pkg::E_NONE,
                                                         r_tline, r_tcol, r_len, '0);
                                n_mode = iat_pkg::M_TOP;
                            end
                        end
                        iat_pkg::M_INTDOT: begin
                            if (r_ci.is_digit) begin
                                // the held dot joins the number
                                n_held   = '0;
                                n_held_v = 1'b0;
                                n_len    = iat_pkg::sat_pos(iat_pkg::sat_pos(r_len));
                                n_col    = iat_pkg::sat_pos(r_col);
                                n_mode   = iat_pkg::M_FRAC;
                                w_adv    = 1'b1;
                            end else begin
                                e_v    = 1'b1;
                                e_tok  = iat_pkg::mk_tok(iat_pkg::K_NUMBER, iat_pkg::E_NONE,
                                                         r_tline, r_tcol, r_len, '0);
                                n_mode = iat_pkg::M_LATEDOT;
                            end
                        end
                        iat_pkg::M_LATEDOT: begin
                            e_v      = 1'b1;
                            e_tok    = iat_pkg::mk_tok(iat_pkg::K_DOT, iat_pkg::E_NONE, r_line,
                                                       (r_col > PW'(1)) ? r_col - PW'(1) : PW'(1),
                                                       PW'(1), '0);
                            n_held   = '0;
                            n_held_v = 1'b0;
                            n_mode   = iat_pkg::M_TOP;
                        end
                        iat_pkg::M_EXP0, iat_pkg::M_EXP1: begin
                            if (r_ci.is_digit
                                || ((r_c == "+" || r_c == "-") && r_mode == iat_pkg::M_EXP0)) begin
                                n_len  = iat_pkg::sat_pos(r_len);
                                n_col  = iat_pkg::sat_pos(r_col);
                                n_mode = r_ci.is_digit ? iat_pkg::M_EXPD : iat_pkg::M_EXP1;
                                w_adv  = 1'b1;
                            end else begin
                                e_v    = 1'b1;
                                e_tok  = iat_pkg::mk_tok(iat_pkg::K_ERROR, iat_pkg::E_EXPONENT,
                                                         r_tline, r_tcol, r_len, '0);
                                n_mode = iat_pkg::M_TOP;
                            end
                        end
                        iat_pkg::M_BINP, iat_pkg::M_BIND: begin
                            if (r_c == "0" || r_c == "1") begin
                                n_acc  = {r_acc[62:0], r_c[0]};
                                n_len  = iat_pkg::sat_pos(r_len);
                                n_col  = iat_pkg::sat_pos(r_col);
                                n_mode = iat_pkg::M_BIND;
                                w_adv  = 1'b1;
                            end else begin
                                e_v = 1'b1;
                                if (r_mode == iat_pkg::M_BINP)
                                    e_tok = iat_pkg::mk_tok(iat_pkg::K_ERROR, iat_pkg::E_BINARY,
                                                            r_tline, r_tcol, r_len, '0);
                                else
                                    e_tok = iat_pkg::mk_tok(iat_pkg::K_NUMBER, iat_pkg::E_NONE,
                                                            r_tline, r_tcol, r_len, r_acc);
                                n_mode = iat_pkg::M_TOP;
                            end
                        end
                        iat_pkg::M_HEXP, iat_pkg::M_HEXD: begin
                            if (r_ci.hex_ok) begin
                                n_acc  = {r_acc[59:0], r_ci.hex_val};
                                n_len  = iat_pkg::sat_pos(r_len);
                                n_col  = iat_pkg::sat_pos(r_col);
                                n_mode = iat_pkg::M_HEXD;
                                w_adv  = 1'b1;
                            end else begin
                                e_v = 1'b1;
                                if (r_mode == iat_pkg::M_HEXP)
                                    e_tok = iat_pkg::mk_tok(iat_pkg::K_ERROR, iat_pkg::E_HEX,
                                                            r_tline, r_tcol, r_len, '0);
                                else
                                    e_tok = iat_pkg::mk_tok(iat_pkg::K_NUMBER, iat_pkg::E_NONE,
                                                            r_tline, r_tcol, r_len, r_acc);
                                n_mode = iat_pkg::M_TOP;
                            end
                        end
                        iat_pkg::M_STR: begin
                            if (r_c == r_quote) begin
                                n_len  = iat_pkg::sat_pos(r_len);
                                n_col  = iat_pkg::sat_pos(r_col);
                                e_v    = 1'b1;
                                e_tok  = iat_pkg::mk_tok(iat_pkg::K_STRING, iat_pkg::E_NONE,
                                                         r_tline, r_tcol, n_len, '0);
                                n_mode = iat_pkg::M_TOP;
                                w_adv  = 1'b1;
                            end else if (r_ci.is_break) begin
                                e_v    = 1'b1;
                                e_tok  = iat_pkg::mk_tok(iat_pkg::K_ERROR, iat_pkg::E_STRING,
                                                         r_tline, r_tcol, r_len, '0);
                                n_mode = iat_pkg::M_TOP;
                            end else begin
                                if (r_c == 8'h5C) n_mode = iat_pkg::M_ESC;
                                n_len = iat_pkg::sat_pos(r_len);
                                n_col = iat_pkg::sat_pos(r_col);
                                w_adv = 1'b1;
                            end
                        end
                        iat_pkg::M_ESC: begin
                            n_len  = iat_pkg::sat_pos(r_len);
                            n_col  = iat_pkg::sat_pos(r_col);
                            n_mode = iat_pkg::M_STR;
                            w_adv  = 1'b1;
                        end
                        iat_pkg::M_IDENT: begin
                            if (r_ci.is_alpha || r_ci.is_digit) begin
                                wd_we = (r_len < PW'(iat_pkg::WORD_LEN));
                                n_len = iat_pkg::sat_pos(r_len);
                                n_col = iat_pkg::sat_pos(r_col);
                                w_adv = 1'b1;
                            end else begin
                                e_v    = 1'b1;
                                e_tok  = iat_pkg::mk_tok(iat_pkg::word_kind(r_word, r_len),
                                                         iat_pkg::E_NONE, r_tline, r_tcol,
                                                         r_len, '0);
                                n_mode = iat_pkg::M_TOP;
                            end
                        end
                        iat_pkg::M_OP: begin
                            e_v      = 1'b1;
                            n_held   = '0;
                            n_held_v = 1'b0;
                            n_mode   = iat_pkg::M_TOP;
                            if (w_pk != iat_pkg::K_NONE) begin
                                n_len = iat_pkg::sat_pos(r_len);
                                n_col = iat_pkg::sat_pos(r_col);
                                e_tok = iat_pkg::mk_tok(w_pk, iat_pkg::E_NONE,
                                                        r_tline, r_tcol, n_len, '0);
                                w_adv = 1'b1;
                            end else if (iat_pkg::single_kind(r_held) != iat_pkg::K_NONE) begin
                                e_tok = iat_pkg::mk_tok(iat_pkg::single_kind(r_held),
                                                        iat_pkg::E_NONE, r_tline, r_tcol,
                                                        r_len, '0);
                            end else begin
                                e_tok = iat_pkg::mk_tok(iat_pkg::K_ERROR, iat_pkg::E_BADCHAR,
                                                        r_tline, r_tcol, r_len, '0);
                            end
                        end
                        default: begin
                            n_mode = iat_pkg::M_TOP;
                        end
                    endcase
                end

                iat_pkg::PH_FLUSH: begin
                    w_adv = 1'b1;
                    e_v   = 1'b1;
                    case (r_mode)
                        iat_pkg::M_CR:
                            e_tok = iat_pkg::mk_tok(iat_pkg::K_NEWLINE, iat_pkg::E_NONE,
                                                    r_tline, r_tcol, PW'(1), '0);
                        iat_pkg::M_DOT:
                            e_tok = iat_pkg::mk_tok(iat_pkg::K_DOT, iat_pkg::E_NONE,
                                                    r_tline, r_tcol, r_len, '0);
                        iat_pkg::M_ZERO, iat_pkg::M_INT, iat_pkg::M_FRAC, iat_pkg::M_EXPD:
                            e_tok = iat_pkg::mk_tok(iat_pkg::K_NUMBER, iat_pkg::E_NONE,
                                                    r_tline, r_tcol, r_len, '0);
                        iat_pkg::M_INTDOT: begin
                            e_tok  = iat_pkg::mk_tok(iat_pkg::K_NUMBER, iat_pkg::E_NONE,
                                                     r_tline, r_tcol, r_len, '0);
                            n_mode = iat_pkg::M_LATEDOT;
                            w_adv  = 1'b0;
                        end
                        iat_pkg::M_LATEDOT: begin
                            e_tok    = iat_pkg::mk_tok(iat_pkg::K_DOT, iat_pkg::E_NONE, r_line,
                                                       (r_col > PW'(1)) ? r_col - PW'(1) : PW'(1),
                                                       PW'(1), '0);
                            n_held   = '0;
                            n_held_v = 1'b0;
                            n_mode   = iat_pkg::M_TOP;
                        end
                        iat_pkg::M_EXP0, iat_pkg::M_EXP1:
                            e_tok = iat_pkg::mk_tok(iat_pkg::K_ERROR, iat_pkg::E_EXPONENT,
                                                    r_tline, r_tcol, r_len, '0);
                        iat_pkg::M_BINP:
                            e_tok = iat_pkg::mk_tok(iat_pkg::K_ERROR, iat_pkg::E_BINARY,
                                                    r_tline, r_tcol, r_len, '0);
                        iat_pkg::M_HEXP:
                            e_tok = iat_pkg::mk_tok(iat_pkg::K_ERROR, iat_pkg::E_HEX,
                                                    r_tline, r_tcol, r_len, '0);
                        iat_pkg::M_BIND, iat_pkg::M_HEXD:
                            e_tok = iat_pkg::mk_tok(iat_pkg::K_NUMBER, iat_pkg::E_NONE,
                                                    r_tline, r_tcol, r_len, r_acc);
                        iat_pkg::M_STR, iat_pkg::M_ESC:
                            e_tok = iat_pkg::mk_tok(iat_pkg::K_ERROR, iat_pkg::E_STRING,
                                                    r_tline, r_tcol, r_len, '0);
                        iat_pkg::M_IDENT:
                            e_tok = iat_pkg::mk_tok(iat_pkg::word_kind(r_word, r_len),
                                                    iat_pkg::E_NONE, r_tline, r_tcol, r_len, '0);
                        iat_pkg::M_OP: begin
                            n_held   = '0;
                            n_held_v = 1'b0;
                            if (iat_pkg::single_kind(r_held) != iat_pkg::K_NONE)
                                e_tok = iat_pkg::mk_tok(iat_pkg::single_kind(r_held),
                                                        iat_pkg::E_NONE, r_tline, r_tcol,
                                                        r_len, '0);
                            else
                                e_tok = iat_pkg::mk_tok(iat_pkg::K_ERROR, iat_pkg::E_BADCHAR,
                                                        r_tline, r_tcol, r_len, '0);
                        end
                        default: e_v = 1'b0;
                    endcase
                end

                iat_pkg::PH_NL: begin
                    if (r_emitted && !r_lastnl) begin
                        e_v   = 1'b1;
                        e_tok = iat_pkg::mk_tok(iat_pkg::K_NEWLINE, iat_pkg::E_NONE,
                                                r_line, r_col, '0, '0);
                    end
                end

                iat_pkg::PH_DED: begin
                    if (r_lvl_cnt > LW'(1)) begin
                        n_lvl_cnt = r_lvl_cnt - LW'(1);
                        e_v   = 1'b1;
                        e_tok = iat_pkg::mk_tok(iat_pkg::K_DEDENT, iat_pkg::E_NONE,
                                                r_line, r_col, '0, '0);
                    end else begin
                        w_adv = 1'b1;
                    end
                end

                iat_pkg::PH_EOF: begin
                    e_v       = 1'b1;
                    e_tok     = iat_pkg::mk_tok(iat_pkg::K_EOF, iat_pkg::E_NONE,
                                                r_line, r_col, '0, '0);
                    // back to the reset state
                    n_mode    = iat_pkg::M_LINE;
                    n_lvl_cnt = LW'(1);
                    n_line    = PW'(1);
                    n_col     = PW'(1);
                    n_tline   = PW'(1);
                    n_tcol    = PW'(1);
                    n_len     = '0;
                    n_lead    = '0;
                    n_acc     = '0;
                    n_held    = '0;
                    n_held_v  = 1'b0;
                    n_quote   = '0;
                end

                default: begin
                    e_v = 1'b0;
                end
            endcase

            if (e_v) begin
                n_emitted = 1'b1;
                n_lastnl  = (e_tok.kind == iat_pkg::K_NEWLINE);
            end
            if (r_phase == iat_pkg::PH_EOF) begin
                n_emitted = 1'b0;
                n_lastnl  = 1'b0;
            end
        end
    end

    // next phase
    always_comb begin
        n_phase = r_phase;
        case (r_phase)
            iat_pkg::PH_FETCH: begin
                if (i_in_valid)
                    n_phase = (i_in_func == iat_pkg::FUNC_END) ? iat_pkg::PH_FLUSH
                                                               : iat_pkg::PH_FEED;
            end
            iat_pkg::PH_FEED:  if (w_act && w_adv) n_phase = iat_pkg::PH_END;
            iat_pkg::PH_FLUSH: if (w_act && w_adv) n_phase = iat_pkg::PH_NL;
            iat_pkg::PH_NL:    if (w_act) n_phase = iat_pkg::PH_DED;
            iat_pkg::PH_DED:   if (w_act && w_adv) n_phase = iat_pkg::PH_EOF;
            iat_pkg::PH_EOF:   if (w_act) n_phase = iat_pkg::PH_END;
            iat_pkg::PH_END:   if (!r_pend_v || !i_out_full) n_phase = iat_pkg::PH_FETCH;
            default:           n_phase = iat_pkg::PH_FETCH;
        endcase
    end

    // handshake outputs
    always_comb begin
        o_in_pop   = (r_phase == iat_pkg::PH_FETCH) && i_in_valid;
        o_out_push = (w_act && e_v && r_pend_v) || w_end_push;
        o_out_tok  = r_pend;
        o_out_tok.last = (r_phase == iat_pkg::PH_END);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= iat_pkg::PH_FETCH;
            r_mode    <= iat_pkg::M_LINE;
            r_lvl_cnt <= LW'(1);
            r_line    <= PW'(1);
            r_col     <= PW'(1);
            r_tline   <= PW'(1);
            r_tcol    <= PW'(1);
            r_len     <= '0;
            r_lead    <= '0;
            r_acc     <= '0;
            r_held    <= '0;
            r_held_v  <= 1'b0;
            r_quote   <= '0;
            r_emitted <= 1'b0;
            r_lastnl  <= 1'b0;
            r_pend_v  <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_mode    <= n_mode;
            r_lvl_cnt <= n_lvl_cnt;
            r_line    <= n_line;
            r_col     <= n_col;
            r_tline   <= n_tline;
            r_tcol    <= n_tcol;
            r_len     <= n_len;
            r_lead    <= n_lead;
            r_acc     <= n_acc;
            r_held    <= n_held;
            r_held_v  <= n_held_v;
            r_quote   <= n_quote;
            r_emitted <= n_emitted;
            r_lastnl  <= n_lastnl;
            if (w_act && e_v) r_pend_v <= 1'b1;
            else if (w_end_push) r_pend_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_pop) begin
            r_c  <= i_in_byte;
            r_ci <= i_in_info;
        end
        if (w_act && e_v) r_pend <= e_tok;
        if (lv_we) r_levels[iat_pkg::LVL_IDX_W'(r_lvl_cnt)] <= lv_data;
        if (w_act && wd_we) r_word[wd_idx] <= r_c;
    end

    a_lvl_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lvl_cnt != '0 && r_lvl_cnt <= LW'(iat_pkg::INDENT_DEPTH))
        else $error("indent level count out of range");

    a_eof_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == iat_pkg::PH_EOF && w_act) |=> (r_lvl_cnt == LW'(1)
                                                   && r_mode == iat_pkg::M_LINE))
        else $error("end of text left levels open");

    a_step_boundary: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == iat_pkg::PH_END) |-> !(r_mode == iat_pkg::M_IND
                                           || r_mode == iat_pkg::M_DED
                                           || r_mode == iat_pkg::M_LATEDOT))
        else $error("transaction ended inside an internal mode");

    a_push_has_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_push |-> (r_pend_v && !i_out_full))
        else $error("result pushed without a pending token or into a full queue");

endmodule

### hdl/indent_aware_tokenizer.sv
// top level of the indentation-aware tokenizer
//
// Input channel: push/full. Each transaction is one source byte (i_func = 0)
// or an end-of-text mark (i_func = 1), which flushes the pending token, adds
// a closing NEWLINE if needed, closes open indent levels and emits EOF.
// Result channel: empty/pop. The oldest token sits on the o_ ports while
// empty is low; o_last_of_run marks the final token caused by one input.
// Flow: a byte passes the fetch phase, one lexer step after another and a
// closing phase. A byte that ends a token is looked at again, so it takes 1 to
// 4 steps; a DEDENT burst adds one step per DEDENT and one more to leave the
// stack walk. End of text passes the fetch, flush, newline, dedent, EOF and
// closing phases, with one dedent step per open level and one more step for
// a dot held after a number.
// A token is held until the next one is made or the transaction closes, and
// only then is it pushed to the result queue.
// A four-deep queue sits on each side, so input is taken while results wait.
// When the result queue fills the engine holds its one pending token and
// stops; the input queue then fills and full goes high.
// Reset (synchronous, active low) empties both queues and returns to line
// start with one indent level of zero.
`timescale 1ns / 1ps
module indent_aware_tokenizer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic        i_func,
    input  logic [7:0]  i_char_byte,
    output logic        empty,
    input  logic        pop,
    output logic [5:0]  o_token_kind,
    output logic [2:0]  o_error_code,
    output logic [15:0] o_line_number,
    output logic [15:0] o_column_number,
    output logic [15:0] o_token_length,
    output logic [63:0] o_number_value,
    output logic        o_last_of_run
);

    logic                w_in_valid, w_in_func, w_in_pop;
    logic [7:0]          w_in_byte;
    iat_pkg::t_char_info w_in_info;
    logic                w_out_full, w_out_push;
    iat_pkg::t_token     w_push_tok, w_head_tok;

    iat_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_func      (i_func),
        .i_char_byte (i_char_byte),
        .o_valid     (w_in_valid),
        .o_func      (w_in_func),
        .o_byte      (w_in_byte),
        .o_info      (w_in_info),
        .i_pop       (w_in_pop)
    );

    iat_engine u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (w_in_valid),
        .i_in_func  (w_in_func),
        .i_in_byte  (w_in_byte),
        .i_in_info  (w_in_info),
        .o_in_pop   (w_in_pop),
        .i_out_full (w_out_full),
        .o_out_push (w_out_push),
        .o_out_tok  (w_push_tok)
    );

    iat_out_queue u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_out_push),
        .i_tok   (w_push_tok),
        .o_full  (w_out_full),
        .empty   (empty),
        .pop     (pop),
        .o_tok   (w_head_tok)
    );

    assign o_token_kind    = w_head_tok.kind;
    assign o_error_code    = w_head_tok.err;
    assign o_line_number   = w_head_tok.line;
    assign o_column_number = w_head_tok.col;
    assign o_token_length  = w_head_tok.len;
    assign o_number_value  = w_head_tok.val;
    assign o_last_of_run   = w_head_tok.last;

endmodule
